[hw/rtl/rsd_pkg.sv]
package rsd_pkg;

  localparam int CENTER_BITS = 14;
  localparam int RAD_BITS    = 32;
  localparam int ISQ_STEPS   = RAD_BITS / 2;
  localparam int D8_BITS     = 16;
  localparam int FACTOR_BITS = 17;
  localparam int FRAC_SHIFT  = 16;
  localparam int DIV25_SHIFT = 26;
  localparam int DIV25_BITS  = 22;

  localparam logic [FACTOR_BITS-1:0] ONE_Q16    = 17'd65536;
  localparam logic [FACTOR_BITS-1:0] FAR_FACTOR = 17'd13107;
  localparam logic [DIV25_BITS-1:0]  DIV25_MUL  = 22'd2684355;
  localparam logic [31:0]            NEAR_SUM_MAX = 32'd25601;

  localparam logic [0:0] REG_CENTER_COL = 1'b0;
  localparam logic [0:0] REG_CENTER_ROW = 1'b1;

  typedef struct packed {
    logic                valid;
    logic                far;
    logic [RAD_BITS-1:0] rem;
    logic [RAD_BITS-1:0] root;
  } isq_t;

endpackage

[hw/rtl/rsd_front.sv]
module rsd_front #(
  parameter int COORD_BITS = 12,
  parameter int LIGHT_BITS = 16
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   valid,
  input  logic [COORD_BITS-1:0]                  col,
  input  logic [COORD_BITS-1:0]                  row,
  input  logic [LIGHT_BITS-1:0]                  light,
  input  logic signed [rsd_pkg::CENTER_BITS-1:0] center_col,
  input  logic signed [rsd_pkg::CENTER_BITS-1:0] center_row,
  output rsd_pkg::isq_t                          isq_out,
  output logic [LIGHT_BITS-1:0]                  light_out
);

  localparam int CB = rsd_pkg::CENTER_BITS;
  localparam int DW = ((COORD_BITS > CB) ? COORD_BITS : CB) + 2;
  localparam int AW = DW - 1;
  localparam int SW = 2 * AW + 1;

  logic signed [DW-1:0] col_s, row_s, ccol_s, crow_s, dx, dy;
  logic [AW-1:0]        adx_nxt, ady_nxt;
  logic [AW-1:0]        adx_r, ady_r;
  logic [2*AW-1:0]      sqx_r, sqy_r;
  logic [SW-1:0]        sum;
  logic                 v1_r, v2_r;
  logic [LIGHT_BITS-1:0] light1_r, light2_r, light3_r;
  rsd_pkg::isq_t        isq_r;

  assign col_s  = signed'({{(DW-COORD_BITS){1'b0}}, col});
  assign row_s  = signed'({{(DW-COORD_BITS){1'b0}}, row});
  assign ccol_s = {{(DW-CB){center_col[CB-1]}}, center_col};
  assign crow_s = {{(DW-CB){center_row[CB-1]}}, center_row};
  assign dx = col_s - ccol_s;
  assign dy = row_s - crow_s;
  assign adx_nxt = dx[DW-1] ? AW'(-dx) : AW'(dx);
  assign ady_nxt = dy[DW-1] ? AW'(-dy) : AW'(dy);

  assign sum = {1'b0, sqx_r} + {1'b0, sqy_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      isq_r.valid <= 1'b0;
    end else begin
      v1_r        <= valid;
      v2_r        <= v1_r;
      isq_r.valid <= v2_r;
    end
    adx_r      <= adx_nxt;
    ady_r      <= ady_nxt;
    light1_r   <= light;
    sqx_r      <= adx_r * adx_r;
    sqy_r      <= ady_r * ady_r;
    light2_r   <= light1_r;
    isq_r.far  <= sum > SW'(rsd_pkg::NEAR_SUM_MAX);
    isq_r.rem  <= {1'b0, sum[14:0], 16'd0};
    isq_r.root <= '0;
    light3_r   <= light2_r;
  end

  assign isq_out   = isq_r;
  assign light_out = light3_r;

endmodule

[hw/rtl/rsd_cell.sv]
module rsd_cell #(
  parameter int STEP       = 0,
  parameter int LIGHT_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  rsd_pkg::isq_t         cell_in,
  input  logic [LIGHT_BITS-1:0] light_in,
  output rsd_pkg::isq_t         cell_out,
  output logic [LIGHT_BITS-1:0] light_out
);

  localparam int RB = rsd_pkg::RAD_BITS;
  localparam logic [RB-1:0] BIT_MASK = RB'(1) << (RB - 2 - 2 * STEP);

  logic [RB:0]           trial;
  logic                  take;
  logic [RB-1:0]         rem_nxt, root_nxt;
  rsd_pkg::isq_t         cell_r;
  logic [LIGHT_BITS-1:0] light_r;

  assign trial    = {1'b0, cell_in.root} + {1'b0, BIT_MASK};
  assign take     = {1'b0, cell_in.rem} >= trial;
  assign rem_nxt  = take ? cell_in.rem - trial[RB-1:0] : cell_in.rem;
  assign root_nxt = take ? (cell_in.root >> 1) + BIT_MASK : cell_in.root >> 1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r.valid <= 1'b0;
    end else begin
      cell_r.valid <= cell_in.valid;
    end
    cell_r.far  <= cell_in.far;
    cell_r.rem  <= rem_nxt;
    cell_r.root <= root_nxt;
    light_r     <= light_in;
  end

  assign cell_out  = cell_r;
  assign light_out = light_r;

endmodule

[hw/rtl/rsd_scale.sv]
module rsd_scale #(
  parameter int LIGHT_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  rsd_pkg::isq_t         isq_in,
  input  logic [LIGHT_BITS-1:0] light_in,
  output logic                  valid_out,
  output logic [LIGHT_BITS-1:0] light_out
);

  localparam int FB = rsd_pkg::FACTOR_BITS;
  localparam int XB = rsd_pkg::D8_BITS + 5;
  localparam int PB = XB + rsd_pkg::DIV25_BITS;
  localparam int OB = LIGHT_BITS + FB;

  logic [XB-1:0]         x;
  logic [PB-1:0]         div_r;
  logic [FB-1:0]         quot;
  logic [FB-1:0]         factor_nxt, factor_r;
  logic                  v1_r, v2_r, v3_r, far1_r;
  logic [LIGHT_BITS-1:0] light1_r, light2_r;
  logic [OB-1:0]         prod_r;

  assign x    = {isq_in.root[rsd_pkg::D8_BITS-1:0], 5'd0};
  assign quot = div_r[rsd_pkg::DIV25_SHIFT +: FB];
  assign factor_nxt = far1_r ? rsd_pkg::FAR_FACTOR : rsd_pkg::ONE_Q16 - quot;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= isq_in.valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
    div_r    <= x * rsd_pkg::DIV25_MUL;
    far1_r   <= isq_in.far;
    light1_r <= light_in;
    factor_r <= factor_nxt;
    light2_r <= light1_r;
    prod_r   <= light2_r * factor_r;
  end

  assign valid_out = v3_r;
  assign light_out = prod_r[rsd_pkg::FRAC_SHIFT +: LIGHT_BITS];

endmodule

[hw/rtl/radial_spotlight_dimmer.sv]
// Channel   Ports                                       Transaction
// input     start, busy, in_col, in_row, in_light_in    start && !busy
// result    out_valid, out_light_out                    out_valid, one cycle
// config    cfg_valid, cfg_ready, cfg_index, cfg_data   cfg_valid && cfg_ready
//
// One pixel per cycle; busy stays low. The result follows the transaction
// through 3 distance stages, 16 square-root cells, 3 scaling stages.
// Synchronous active-low reset clears the pipeline valids and both centers.
// The result channel has no stall; each result shows for a single cycle.
module radial_spotlight_dimmer #(
  parameter int COORD_BITS = 12,
  parameter int LIGHT_BITS = 16
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  output logic                                   busy,
  input  logic [COORD_BITS-1:0]                  in_col,
  input  logic [COORD_BITS-1:0]                  in_row,
  input  logic [LIGHT_BITS-1:0]                  in_light_in,
  output logic                                   out_valid,
  output logic [LIGHT_BITS-1:0]                  out_light_out,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [0:0]                             cfg_index,
  input  logic signed [rsd_pkg::CENTER_BITS-1:0] cfg_data
);

  localparam int STEPS   = rsd_pkg::ISQ_STEPS;
  localparam int LATENCY = 3 + STEPS + 3;

  logic signed [rsd_pkg::CENTER_BITS-1:0] center_col_r, center_row_r;
  logic                  accept;
  rsd_pkg::isq_t         isq_s [0:STEPS];
  logic [LIGHT_BITS-1:0] light_s [0:STEPS];

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_col_r <= '0;
      center_row_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        rsd_pkg::REG_CENTER_COL: center_col_r <= cfg_data;
        rsd_pkg::REG_CENTER_ROW: center_row_r <= cfg_data;
      endcase
    end
  end

  rsd_front #(
    .COORD_BITS(COORD_BITS),
    .LIGHT_BITS(LIGHT_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .valid      (accept),
    .col        (in_col),
    .row        (in_row),
    .light      (in_light_in),
    .center_col (center_col_r),
    .center_row (center_row_r),
    .isq_out    (isq_s[0]),
    .light_out  (light_s[0])
  );

  for (genvar g = 0; g < STEPS; g++) begin : g_cell
    rsd_cell #(
      .STEP      (g),
      .LIGHT_BITS(LIGHT_BITS)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_in  (isq_s[g]),
      .light_in (light_s[g]),
      .cell_out (isq_s[g+1]),
      .light_out(light_s[g+1])
    );
  end

  rsd_scale #(
    .LIGHT_BITS(LIGHT_BITS)
  ) u_scale (
    .clk      (clk),
    .rst_n    (rst_n),
    .isq_in   (isq_s[STEPS]),
    .light_in (light_s[STEPS]),
    .valid_out(out_valid),
    .light_out(out_light_out)
  );

`ifndef SYNTHESIS
  logic [LIGHT_BITS+rsd_pkg::FACTOR_BITS-1:0] floor_prod;
  assign floor_prod = in_light_in * rsd_pkg::FAR_FACTOR;

  a_out_from_txn: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, LATENCY))
    else $error("result without matching input transaction");

  a_out_not_brighter: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_light_out <= $past(in_light_in, LATENCY))
    else $error("dimmed lightness exceeds input lightness");

  a_out_floor: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_light_out >=
      LIGHT_BITS'($past(floor_prod, LATENCY) >> rsd_pkg::FRAC_SHIFT))
    else $error("dimmed lightness below far-field floor");
`endif

endmodule
